[hw/rtl/wsfr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wsfr_pkg
// Shared types and constants for the websocket frame receiver: event codes,
// the parsed-operation record passed from the front end to the back end,
// and the depth of the queue between them.
// ----------------------------------------------------------------------------
package wsfr_pkg;

  localparam int unsigned MaxPayloadW  = 21;
  localparam logic [MaxPayloadW-1:0] MaxPayloadRst = MaxPayloadW'(8192);

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  localparam logic [3:0] OpcClose = 4'h8;
  localparam logic [6:0] Len16    = 7'd126;
  localparam logic [6:0] Len64    = 7'd127;

  typedef enum logic [1:0] {
    EV_DATA     = 2'd0,
    EV_EMPTY    = 2'd1,
    EV_CLOSE    = 2'd2,
    EV_OVERSIZE = 2'd3
  } event_t;

  typedef struct packed {
    event_t     ev;
    logic [7:0] data;
    logic [7:0] key;
    logic       last;
    logic [3:0] opcode;
  } op_t;

endpackage
`default_nettype wire

[hw/rtl/wsfr_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wsfr_front
// Header parser. Accepts one link byte per cycle while accept is high, tracks
// the frame phase, length and mask key, and queues one operation per result.
// ----------------------------------------------------------------------------
module wsfr_front (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  accept,
  input  wire  [7:0]                           rx_byte,
  input  wire  [wsfr_pkg::MaxPayloadW-1:0]     max_payload,
  output logic                                 q_push,
  output wsfr_pkg::op_t                        q_op
);
  import wsfr_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_SKIP    = 3'd5,
    PH_ERROR   = 3'd6
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic [2:0]  extcnt_r, extcnt_nxt;
  logic [63:0] remain_r, remain_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  idx_r, idx_nxt;

  logic [63:0] remain_dec;
  logic        remain_one;
  logic        remain_zero;
  logic        oversize;
  logic [7:0]  key_byte;

  assign remain_dec  = remain_r - 64'd1;
  assign remain_one  = (remain_r == 64'd1);
  assign remain_zero = (remain_r == 64'd0);
  assign oversize    = (|remain_r[63:MaxPayloadW]) || (remain_r[MaxPayloadW-1:0] > max_payload);

  always_comb begin
    case (idx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    extcnt_nxt = extcnt_r;
    remain_nxt = remain_r;
    key_nxt    = key_r;
    idx_nxt    = idx_r;
    q_push     = 1'b0;
    q_op       = '{ev: EV_DATA, data: 8'd0, key: 8'd0, last: 1'b1, opcode: opcode_r};
    if (accept) begin
      case (phase_r)
        PH_HDR1: begin
          remain_nxt = 64'd0;
          idx_nxt    = 2'd0;
          key_nxt    = 32'd0;
          if (rx_byte[6:0] == Len16) begin
            extcnt_nxt = 3'd1;
            phase_nxt  = PH_EXTLEN;
          end else if (rx_byte[6:0] == Len64) begin
            extcnt_nxt = 3'd7;
            phase_nxt  = PH_EXTLEN;
          end else begin
            remain_nxt = {57'd0, rx_byte[6:0]};
            phase_nxt  = PH_MASK;
          end
        end
        PH_EXTLEN: begin
          remain_nxt = {remain_r[55:0], rx_byte};
          if (extcnt_r == 3'd0) begin
            phase_nxt = PH_MASK;
          end else begin
            extcnt_nxt = extcnt_r - 3'd1;
          end
        end
        PH_MASK: begin
          key_nxt = {key_r[23:0], rx_byte};
          idx_nxt = idx_r + 2'd1;
          if (idx_r == 2'd3) begin
            if (opcode_r == OpcClose) begin
              phase_nxt = remain_zero ? PH_HDR0 : PH_SKIP;
              q_push    = 1'b1;
              q_op.ev   = EV_CLOSE;
            end else if (oversize) begin
              phase_nxt = PH_ERROR;
              q_push    = 1'b1;
              q_op.ev   = EV_OVERSIZE;
            end else if (remain_zero) begin
              phase_nxt = PH_HDR0;
              q_push    = 1'b1;
              q_op.ev   = EV_EMPTY;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          idx_nxt    = idx_r + 2'd1;
          remain_nxt = remain_dec;
          q_push     = 1'b1;
          q_op.data  = rx_byte;
          q_op.key   = key_byte;
          q_op.last  = remain_one;
          if (remain_one) begin
            phase_nxt = PH_HDR0;
          end
        end
        PH_SKIP: begin
          remain_nxt = remain_dec;
          if (remain_one) begin
            phase_nxt = PH_HDR0;
          end
        end
        PH_ERROR: begin
          phase_nxt = PH_ERROR;
        end
        default: begin
          opcode_nxt = rx_byte[3:0];
          phase_nxt  = PH_HDR1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      opcode_r <= 4'd0;
      extcnt_r <= 3'd0;
      remain_r <= 64'd0;
      key_r    <= 32'd0;
      idx_r    <= 2'd0;
    end else begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      extcnt_r <= extcnt_nxt;
      remain_r <= remain_nxt;
      key_r    <= key_nxt;
      idx_r    <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/wsfr_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wsfr_queue
// Short FIFO of parsed operations between the front end and the back end.
// ----------------------------------------------------------------------------
module wsfr_queue (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            push,
  input  wsfr_pkg::op_t  push_op,
  output logic           full,
  input  wire            pop,
  output logic           valid,
  output wsfr_pkg::op_t  head_op
);
  import wsfr_pkg::*;

  op_t            mem_r [QDepth];
  logic [QAw-1:0] wptr_r, wptr_nxt;
  logic [QAw-1:0] rptr_r, rptr_nxt;
  logic [QAw:0]   cnt_r, cnt_nxt;
  logic           do_push;
  logic           do_pop;

  assign full    = (cnt_r == (QAw+1)'(QDepth));
  assign valid   = (cnt_r != '0);
  assign head_op = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wptr_nxt = do_push ? wptr_r + QAw'(1) : wptr_r;
    rptr_nxt = do_pop ? rptr_r + QAw'(1) : rptr_r;
    cnt_nxt  = cnt_r + (QAw+1)'(do_push) - (QAw+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/wsfr_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wsfr_back
// Result stage. Unmasks payload bytes and holds the oldest result in an
// output register until it is popped.
// ----------------------------------------------------------------------------
module wsfr_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  q_valid,
  input  wsfr_pkg::op_t        q_op,
  output logic                 q_pop,
  output logic                 out_empty,
  input  wire                  out_pop,
  output logic [1:0]           out_event_res,
  output logic [7:0]           out_data_byte,
  output logic                 out_last,
  output logic [3:0]           out_frame_opcode
);
  import wsfr_pkg::*;

  logic       valid_r, valid_nxt;
  logic [1:0] ev_r;
  logic [7:0] data_r;
  logic       last_r;
  logic [3:0] opc_r;

  assign q_pop     = q_valid && (!valid_r || out_pop);
  assign valid_nxt = q_pop || (valid_r && !out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ev_r   <= q_op.ev;
      data_r <= q_op.data ^ q_op.key;
      last_r <= q_op.last;
      opc_r  <= q_op.opcode;
    end
  end

  assign out_empty        = !valid_r;
  assign out_event_res    = ev_r;
  assign out_data_byte    = data_r;
  assign out_last         = last_r;
  assign out_frame_opcode = opc_r;

endmodule
`default_nettype wire

[hw/rtl/websocket_frame_receiver.sv]
`default_nettype none
// Path: the edge that accepts a byte writes its result into the queue, then
//   the output register takes it from the queue head for the out_ ports.
// Throughput: one byte per cycle; in_full rises only when the four-entry
//   operation queue fills while results are not popped.
// Reset: synchronous on rst_n; parser returns to the first header byte and
//   max_payload returns to 8192. The block accepts bytes right after reset.
// ----------------------------------------------------------------------------
// websocket_frame_receiver
// Byte-serial websocket frame parser: header front end, operation queue and
// unmasking back end with a result register.
// ----------------------------------------------------------------------------
module websocket_frame_receiver (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_push,
  output logic                             in_full,
  input  wire  [7:0]                       in_rx_byte,
  output logic                             out_empty,
  input  wire                              out_pop,
  output logic [1:0]                       out_event_res,
  output logic [7:0]                       out_data_byte,
  output logic                             out_last,
  output logic [3:0]                       out_frame_opcode,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [wsfr_pkg::MaxPayloadW-1:0] cfg_max_payload
);
  import wsfr_pkg::*;

  logic [MaxPayloadW-1:0] max_payload_r;
  logic                   accept;
  logic                   q_push;
  op_t                    q_in_op;
  logic                   q_full;
  logic                   q_pop;
  logic                   q_valid;
  op_t                    q_head_op;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign accept    = in_push && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MaxPayloadRst;
    end else if (cfg_valid && cfg_ready) begin
      max_payload_r <= cfg_max_payload;
    end
  end

  wsfr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .rx_byte     (in_rx_byte),
    .max_payload (max_payload_r),
    .q_push      (q_push),
    .q_op        (q_in_op)
  );

  wsfr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_in_op),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .head_op (q_head_op)
  );

  wsfr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_op             (q_head_op),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_event_res    (out_event_res),
    .out_data_byte    (out_data_byte),
    .out_last         (out_last),
    .out_frame_opcode (out_frame_opcode)
  );

endmodule
`default_nettype wire
